/* rtl/core/tss_pkg.sv */
// Package for the task scheduler select block: field widths, action and
// slot-state codes, the per-slot table entry and the sequencer states.
// No dependencies.
`default_nettype none

package tss_pkg;

  localparam int ACTION_W   = 3;
  localparam int MASK_W     = 16;
  localparam int TIME_W     = 16;
  localparam int TASK_W     = 4;
  localparam int COUNT_W    = 16;
  localparam int READY_BITS = 16;

  localparam logic [COUNT_W-1:0] TURNS_MAX = 16'hFFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_SELECT = 3'd1,
    ACT_WAIT   = 3'd2,
    ACT_BLOCK  = 3'd3,
    ACT_ADD    = 3'd4,
    ACT_REMOVE = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    SLOT_DEAD    = 2'd0,
    SLOT_RUNNING = 2'd1,
    SLOT_WAITING = 2'd2,
    SLOT_BLOCKED = 2'd3
  } slot_st_t;

  typedef struct packed {
    slot_st_t             st;
    logic [TIME_W-1:0]    timer;
    logic [COUNT_W-1:0]   turns;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{st: SLOT_DEAD, timer: '0, turns: '0};

  // Which walk over the slot table is in progress.
  typedef enum logic [1:0] {
    PASS_SWEEP   = 2'd0,
    PASS_BLOCKED = 2'd1,
    PASS_WAITING = 2'd2,
    PASS_AGING   = 2'd3
  } pass_t;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'd0,
    FSM_SCAN   = 3'd1,
    FSM_RMW_RD = 3'd2,
    FSM_RMW_WR = 3'd3,
    FSM_FINAL  = 3'd4,
    FSM_DONE   = 3'd5
  } fsm_t;

endpackage

`default_nettype wire

/* rtl/core/tss_if.sv */
// Valid/ready channel interfaces for the task scheduler select block.
// Depends on tss_pkg for the field widths.
`default_nettype none

interface tss_in_if import tss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [MASK_W-1:0]   ready_mask;
  logic [TIME_W-1:0]   wait_time;
  logic [TASK_W-1:0]   target_task;

  modport source (output valid, action, ready_mask, wait_time, target_task, input ready);
  modport sink   (input valid, action, ready_mask, wait_time, target_task, output ready);
endinterface

interface tss_out_if import tss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] chosen_task;
  logic              found;

  modport source (output valid, chosen_task, found, input ready);
  modport sink   (input valid, chosen_task, found, output ready);
endinterface

`default_nettype wire

/* rtl/core/tss_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tss_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/task_scheduler_select.sv */
// Task scheduler select block: top level with the slot-table sequencer.
// Depends on tss_pkg, the channel interfaces in tss_if and tss_ram.
//
// Usage. Each beat on the input channel (in_ch) carries one scheduler action:
// tick, select, wait, block, add or remove, together with the ready mask,
// the wait time and the removal target. Every input beat produces exactly
// one beat on the result channel (out_ch) with the chosen task and a found
// flag. The block works on one action at a time; in_ch.ready is high only
// while the sequencer is idle.
//
// Table walks. The slot table sits in one RAM that is read one slot per cycle
// and written back in the following cycle. A tick or an add walks slots 1 to
// TASK_SLOTS-1 once. A select walks the table once per pass, between one and
// three passes. Wait, block and a remove of an in-range target are a single
// read-modify-write. The RAM port, visited once per slot and pass, paces
// these walks.
//
// Reset clears the sequencer, the current task and a valid bit per slot; a
// slot that was never written reads as dead with zero timer and count, so no
// clearing pass is needed. The result sits in an output register: a new
// action can be accepted while a result waits, and a stalled receiver only
// holds the sequencer once the next result is ready to be delivered.
`default_nettype none

module task_scheduler_select import tss_pkg::*; #(
  parameter int TASK_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tss_in_if.sink    in_ch,
  tss_out_if.source out_ch
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int EXT_W = ((IDX_W > TASK_W) ? IDX_W : TASK_W) + 1;
  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(TASK_SLOTS);

  // Sequencer and captured action.
  fsm_t                 state_r, state_nxt;
  action_t              act_r, act_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic [TIME_W-1:0]    wtime_r, wtime_nxt;
  logic [TASK_W-1:0]    target_r, target_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  pass_t                pass_r, pass_nxt;

  // Scan pipeline: one slot is issued to the RAM while the previous one is
  // evaluated and written back.
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic                 prv_vld_r, prv_vld_nxt;
  logic [IDX_W-1:0]     prv_idx_r, prv_idx_nxt;

  // Candidate of the running search.
  logic                 pick_vld_r, pick_vld_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [TIME_W-1:0]    pick_timer_r, pick_timer_nxt;
  logic [COUNT_W-1:0]   best_r, best_nxt;

  // Slot written since reset.
  logic [TASK_SLOTS-1:0] valid_r, valid_nxt;
  logic                  rd_valid_r;

  // Output register.
  logic                 out_vld_r, out_vld_nxt;
  logic [TASK_W-1:0]    out_chosen_r, out_chosen_nxt;
  logic                 out_found_r, out_found_nxt;

  // RAM port.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               wr_entry;
  entry_t               rd_entry;

  logic                 in_fire;
  logic                 issue;
  logic                 scan_end;
  logic                 prv_ready;
  logic                 cur_ready;
  logic                 tgt_in_range;
  logic [IDX_W-1:0]     rmw_addr;
  logic [EXT_W-1:0]     prv_ext;
  logic [EXT_W-1:0]     cur_ext;
  logic [COUNT_W-1:0]   aged;
  logic                 out_load;

  tss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A slot never written since reset reads as dead with cleared counters.
  assign rd_entry = rd_valid_r ? entry_t'(ram_rdata) : ENTRY_RESET;

  assign in_fire  = in_ch.valid && (state_r == FSM_IDLE);
  assign issue    = iss_r < SLOT_END;
  assign scan_end = !issue && !prv_vld_r;

  // Only the first sixteen slots have a ready bit.
  assign prv_ext   = EXT_W'(prv_idx_r);
  assign cur_ext   = EXT_W'(cur_r);
  assign prv_ready = (prv_ext < EXT_W'(READY_BITS)) && mask_r[prv_ext[TASK_W-1:0]];
  assign cur_ready = (cur_ext < EXT_W'(READY_BITS)) && mask_r[cur_ext[TASK_W-1:0]];

  assign tgt_in_range = EXT_W'(in_ch.target_task) < EXT_W'(TASK_SLOTS);
  assign rmw_addr     = (act_r == ACT_REMOVE) ? IDX_W'(target_r) : cur_r;

  // Aging count saturates at its maximum.
  assign aged = (rd_entry.turns == TURNS_MAX) ? rd_entry.turns : rd_entry.turns + 16'd1;

  assign out_load = (state_r == FSM_DONE) && (!out_vld_r || out_ch.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          case (action_t'(in_ch.action))
            ACT_TICK, ACT_SELECT, ACT_ADD: state_nxt = FSM_SCAN;
            ACT_WAIT, ACT_BLOCK:           state_nxt = FSM_RMW_RD;
            ACT_REMOVE:                    state_nxt = tgt_in_range ? FSM_RMW_RD : FSM_DONE;
            default:                       state_nxt = FSM_DONE;
          endcase
        end
      end
      FSM_SCAN: begin
        if (scan_end) begin
          if (pass_r == PASS_SWEEP) begin
            state_nxt = FSM_DONE;
          end else if (pick_vld_r || (pass_r == PASS_AGING)) begin
            state_nxt = FSM_FINAL;
          end
        end
      end
      FSM_RMW_RD: state_nxt = FSM_RMW_WR;
      FSM_RMW_WR: state_nxt = FSM_DONE;
      FSM_FINAL:  state_nxt = FSM_DONE;
      FSM_DONE: begin
        if (out_load) begin
          state_nxt = FSM_IDLE;
        end
      end
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath, RAM controls and output register.
  always_comb begin
    act_nxt        = act_r;
    mask_nxt       = mask_r;
    wtime_nxt      = wtime_r;
    target_nxt     = target_r;
    cur_nxt        = cur_r;
    pass_nxt       = pass_r;
    iss_nxt        = iss_r;
    prv_vld_nxt    = 1'b0;
    prv_idx_nxt    = prv_idx_r;
    pick_vld_nxt   = pick_vld_r;
    pick_nxt       = pick_r;
    pick_timer_nxt = pick_timer_r;
    best_nxt       = best_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_chosen_nxt = out_chosen_r;
    out_found_nxt  = out_found_r;

    ram_raddr = iss_r[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = prv_idx_r;
    wr_entry  = rd_entry;

    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          act_nxt      = action_t'(in_ch.action);
          mask_nxt     = in_ch.ready_mask;
          wtime_nxt    = in_ch.wait_time;
          target_nxt   = in_ch.target_task;
          pick_vld_nxt = 1'b0;
          best_nxt     = '0;
          iss_nxt      = CNT_W'(1);
          pass_nxt     = (action_t'(in_ch.action) == ACT_SELECT) ? PASS_BLOCKED : PASS_SWEEP;
        end
      end
      FSM_SCAN: begin
        prv_vld_nxt = issue;
        prv_idx_nxt = iss_r[IDX_W-1:0];
        if (issue) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (prv_vld_r) begin
          case (pass_r)
            PASS_SWEEP: begin
              if (act_r == ACT_TICK) begin
                if ((rd_entry.st == SLOT_WAITING) && (rd_entry.timer != '0)) begin
                  ram_we         = 1'b1;
                  wr_entry.timer = rd_entry.timer - 16'd1;
                end
              end else if ((rd_entry.st == SLOT_DEAD) && !pick_vld_r) begin
                // Add takes the lowest dead slot.
                ram_we       = 1'b1;
                wr_entry     = '{st: SLOT_RUNNING, timer: '0, turns: '0};
                pick_vld_nxt = 1'b1;
                pick_nxt     = prv_idx_r;
              end
            end
            PASS_BLOCKED: begin
              if ((rd_entry.st == SLOT_BLOCKED) && prv_ready && !pick_vld_r) begin
                pick_vld_nxt   = 1'b1;
                pick_nxt       = prv_idx_r;
                pick_timer_nxt = rd_entry.timer;
              end
            end
            PASS_WAITING: begin
              // The last match wins, which is the highest slot.
              if ((rd_entry.st == SLOT_WAITING) && (rd_entry.timer == '0)) begin
                pick_vld_nxt   = 1'b1;
                pick_nxt       = prv_idx_r;
                pick_timer_nxt = rd_entry.timer;
              end
            end
            PASS_AGING: begin
              if (rd_entry.st == SLOT_RUNNING) begin
                ram_we         = 1'b1;
                wr_entry.turns = aged;
                if (aged > best_r) begin
                  best_nxt       = aged;
                  pick_vld_nxt   = 1'b1;
                  pick_nxt       = prv_idx_r;
                  pick_timer_nxt = rd_entry.timer;
                end
              end
            end
            default: ;
          endcase
        end
        if (scan_end && !pick_vld_r) begin
          if (pass_r == PASS_BLOCKED) begin
            pass_nxt = PASS_WAITING;
            iss_nxt  = CNT_W'(1);
          end else if (pass_r == PASS_WAITING) begin
            pass_nxt = PASS_AGING;
            iss_nxt  = CNT_W'(1);
          end
        end
      end
      FSM_RMW_RD: begin
        ram_raddr = rmw_addr;
      end
      FSM_RMW_WR: begin
        ram_waddr = rmw_addr;
        case (act_r)
          ACT_WAIT: begin
            ram_we         = 1'b1;
            wr_entry.st    = SLOT_WAITING;
            wr_entry.timer = wtime_r;
          end
          ACT_BLOCK: begin
            ram_we      = !cur_ready;
            wr_entry.st = SLOT_BLOCKED;
          end
          ACT_REMOVE: begin
            ram_we      = 1'b1;
            wr_entry.st = SLOT_DEAD;
          end
          default: ;
        endcase
      end
      FSM_FINAL: begin
        // The chosen slot runs with its count cleared; no pick means kernel.
        ram_waddr = pick_r;
        ram_we    = pick_vld_r;
        wr_entry  = '{st: SLOT_RUNNING, timer: pick_timer_r, turns: '0};
        cur_nxt   = pick_vld_r ? pick_r : '0;
      end
      FSM_DONE: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          if (act_r == ACT_ADD) begin
            out_chosen_nxt = pick_vld_r ? TASK_W'(EXT_W'(pick_r)) : '0;
          end else begin
            out_chosen_nxt = TASK_W'(EXT_W'(cur_r));
          end
          out_found_nxt = ((act_r == ACT_ADD) || (act_r == ACT_SELECT)) && pick_vld_r;
        end
      end
      default: ;
    endcase

    valid_nxt = valid_r;
    if (ram_we) begin
      valid_nxt[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FSM_IDLE;
      cur_r      <= '0;
      pass_r     <= PASS_SWEEP;
      iss_r      <= '0;
      prv_vld_r  <= 1'b0;
      pick_vld_r <= 1'b0;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      pass_r     <= pass_nxt;
      iss_r      <= iss_nxt;
      prv_vld_r  <= prv_vld_nxt;
      pick_vld_r <= pick_vld_nxt;
      valid_r    <= valid_nxt;
      rd_valid_r <= valid_r[ram_raddr];
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    mask_r       <= mask_nxt;
    wtime_r      <= wtime_nxt;
    target_r     <= target_nxt;
    prv_idx_r    <= prv_idx_nxt;
    pick_r       <= pick_nxt;
    pick_timer_r <= pick_timer_nxt;
    best_r       <= best_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign in_ch.ready        = (state_r == FSM_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.chosen_task = out_chosen_r;
  assign out_ch.found       = out_found_r;

endmodule

`default_nettype wire
